>>> sv/tlsau_pkg.sv
// ----------------------------------------------------------------------------
// tlsau_pkg: Thumb load/store address unit shared definitions
// Format codes, access width codes, opcode constants and the access
// descriptor type used between the decoder and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsau_pkg;

    // Instruction format selector
    typedef enum logic [3:0] {
        KIND_REG_OFFSET = 4'd0,
        KIND_WORD_IMM   = 4'd1,
        KIND_HALF_IMM   = 4'd2,
        KIND_BYTE_IMM   = 4'd3,
        KIND_PC_REL     = 4'd4,
        KIND_SP_REL     = 4'd5,
        KIND_PUSH       = 4'd6,
        KIND_POP        = 4'd7,
        KIND_MULTIPLE   = 4'd8
    } kind_t;

    // Access width codes
    localparam logic [1:0] WIDTH_BYTE = 2'd0;
    localparam logic [1:0] WIDTH_HALF = 2'd1;
    localparam logic [1:0] WIDTH_WORD = 2'd2;

    // Register offset opcodes (bits 11:9)
    localparam logic [2:0] OP_STR   = 3'd0;
    localparam logic [2:0] OP_STRH  = 3'd1;
    localparam logic [2:0] OP_STRB  = 3'd2;
    localparam logic [2:0] OP_LDRSB = 3'd3;
    localparam logic [2:0] OP_LDR   = 3'd4;
    localparam logic [2:0] OP_LDRH  = 3'd5;
    localparam logic [2:0] OP_LDRB  = 3'd6;
    localparam logic [2:0] OP_LDRSH = 3'd7;

    // Fixed register numbers and list bits
    localparam logic [3:0]  REG_SP       = 4'd13;
    localparam logic [3:0]  REG_PC       = 4'd15;
    localparam logic [15:0] LIST_LR_BIT  = 16'h4000;
    localparam logic [15:0] LIST_PC_BIT  = 16'h8000;
    localparam logic [4:0]  EMPTY_COUNT  = 5'd16;

    // Packed widths of the stream payloads
    localparam int IN_DATA_W  = 80;
    localparam int KIND_W     = 4;
    localparam int OUT_DATA_W = 96;

    // Access descriptor
    typedef struct packed {
        logic        is_multiple;
        logic        writeback_enable;
        logic [31:0] writeback_address;
        logic [3:0]  base_register;
        logic [15:0] register_list;
        logic [2:0]  data_register;
        logic        sign_extend;
        logic [1:0]  access_width;
        logic        is_load;
        logic [31:0] address;
    } access_t;

    // Access width for each register offset opcode
    function automatic logic [1:0] op_width(input logic [2:0] op);
        logic [1:0] w;
        unique case (op)
            OP_STR, OP_LDR:            w = WIDTH_WORD;
            OP_STRH, OP_LDRH, OP_LDRSH: w = WIDTH_HALF;
            default:                   w = WIDTH_BYTE;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/tlsau_decode.sv
// ----------------------------------------------------------------------------
// tlsau_decode: load/store instruction decode and address generation
// Combinational: turns one instruction, its format and register values
// into an access descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsau_decode (
    input  wire logic [3:0]       kind,
    input  wire logic [15:0]      instr,
    input  wire logic [31:0]      base_value,
    input  wire logic [31:0]      index_value,
    input  wire logic             older_core_mode,
    output tlsau_pkg::access_t    result
);
    import tlsau_pkg::*;

    logic [2:0]  op;
    logic [4:0]  imm5;
    logic [7:0]  imm8;
    logic [8:0]  full_list;
    logic [4:0]  count;
    logic [4:0]  pop_count;
    logic [6:0]  byte_count;
    logic [15:0] list;
    logic [31:0] pc_aligned;

    assign op         = instr[11:9];
    assign imm5       = instr[10:6];
    assign imm8       = instr[7:0];
    assign pc_aligned = {base_value[31:2], 2'b00};

    // Register list for stack and multiple forms
    assign full_list = (kind == KIND_MULTIPLE) ? {1'b0, imm8} : instr[8:0];

    // Population count of the nine list bits
    always_comb
    begin
        pop_count = '0;
        for (int i = 0; i < 9; i++)
        begin
            pop_count = pop_count + {4'd0, full_list[i]};
        end
    end

    // Empty list counts as sixteen registers
    always_comb
    begin
        list  = {8'd0, imm8};
        count = pop_count;
        if (full_list == 9'd0)
        begin
            count = EMPTY_COUNT;
            list  = older_core_mode ? LIST_PC_BIT : 16'd0;
        end
        else if (kind != KIND_MULTIPLE && full_list[8])
        begin
            list = list | ((kind == KIND_PUSH) ? LIST_LR_BIT : LIST_PC_BIT);
        end
    end

    assign byte_count = {count, 2'b00};

    // Descriptor by format
    always_comb
    begin
        result = '0;
        unique case (kind)
            KIND_REG_OFFSET:
            begin
                result.address       = base_value + index_value;
                result.data_register = instr[2:0];
                result.base_register = {1'b0, instr[5:3]};
                result.access_width  = op_width(op);
                result.is_load       = (op >= OP_LDRSB);
                result.sign_extend   = (op == OP_LDRSB) || (op == OP_LDRSH);
            end
            KIND_WORD_IMM:
            begin
                result.address       = base_value + {25'd0, imm5, 2'b00};
                result.data_register = instr[2:0];
                result.base_register = {1'b0, instr[5:3]};
                result.access_width  = WIDTH_WORD;
                result.is_load       = instr[11];
            end
            KIND_HALF_IMM:
            begin
                result.address       = base_value + {26'd0, imm5, 1'b0};
                result.data_register = instr[2:0];
                result.base_register = {1'b0, instr[5:3]};
                result.access_width  = WIDTH_HALF;
                result.is_load       = instr[11];
            end
            KIND_BYTE_IMM:
            begin
                result.address       = base_value + {27'd0, imm5};
                result.data_register = instr[2:0];
                result.base_register = {1'b0, instr[5:3]};
                result.access_width  = WIDTH_BYTE;
                result.is_load       = instr[11];
            end
            KIND_PC_REL:
            begin
                result.address       = pc_aligned + {22'd0, imm8, 2'b00};
                result.data_register = instr[10:8];
                result.base_register = REG_PC;
                result.access_width  = WIDTH_WORD;
                result.is_load       = 1'b1;
            end
            KIND_SP_REL:
            begin
                result.address       = base_value + {22'd0, imm8, 2'b00};
                result.data_register = instr[10:8];
                result.base_register = REG_SP;
                result.access_width  = WIDTH_WORD;
                result.is_load       = instr[11];
            end
            KIND_PUSH:
            begin
                result.writeback_address = base_value - {25'd0, byte_count};
                result.address           = result.writeback_address;
                result.register_list     = list;
                result.base_register     = REG_SP;
                result.access_width      = WIDTH_WORD;
                result.writeback_enable  = 1'b1;
                result.is_multiple       = 1'b1;
            end
            KIND_POP:
            begin
                result.address           = base_value;
                result.writeback_address = base_value + {25'd0, byte_count};
                result.register_list     = list;
                result.base_register     = REG_SP;
                result.access_width      = WIDTH_WORD;
                result.is_load           = 1'b1;
                result.writeback_enable  = 1'b1;
                result.is_multiple       = 1'b1;
            end
            KIND_MULTIPLE:
            begin
                result.address           = base_value;
                result.writeback_address = base_value + {25'd0, byte_count};
                result.register_list     = list;
                result.base_register     = {1'b0, instr[10:8]};
                result.access_width      = WIDTH_WORD;
                result.is_load           = instr[11];
                // load with base in list keeps the loaded value
                result.writeback_enable  = !(instr[11] && list[{1'b0, instr[10:8]}]);
                result.is_multiple       = 1'b1;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/thumb_load_store_address_unit.sv
// ----------------------------------------------------------------------------
// thumb_load_store_address_unit: Thumb load/store address generation
// Input register, decode logic, result register; one transaction per cycle unless the output stalls.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   s_axis   | in        | tuser kind; tdata instr, base_value, index_value
//   m_axis   | out       | tdata access descriptor
//   cfg      | in        | cfg_we / cfg_wdata: older_core_mode
//
// The result of an accepted transaction passes from the input register through
// the decode logic into the result register, which presents it on m_axis;
// one transaction is accepted every cycle while the output is not stalled, with
// the single decode stage between the input register and the result register.
// A stalled result holds in the result register while the input register
// still takes one more transaction. rst_n clears both valid flags and the
// mode register; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module thumb_load_store_address_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // slave stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [15:0] instr, [47:16] base_value, [79:48] index_value
    input  wire logic [tlsau_pkg::IN_DATA_W-1:0]   s_tdata,
    // [3:0] kind
    input  wire logic [tlsau_pkg::KIND_W-1:0]      s_tuser,
    // master stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] address, [32] is_load, [34:33] access_width, [35] sign_extend,
    // [38:36] data_register, [54:39] register_list, [58:55] base_register,
    // [90:59] writeback_address, [91] writeback_enable, [92] is_multiple,
    // [95:93] zero
    output logic [tlsau_pkg::OUT_DATA_W-1:0]       m_tdata,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_wdata
);
    import tlsau_pkg::*;

    logic                  mode_reg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [IN_DATA_W-1:0]  data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    access_t               res_reg;
    access_t               res_next;
    logic                  advance;
    logic                  in_take;

    // Handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= s_tuser;
            data_reg <= s_tdata;
        end
    end

    // Decode
    tlsau_decode u_decode (
        .kind            (kind_reg),
        .instr           (data_reg[15:0]),
        .base_value      (data_reg[47:16]),
        .index_value     (data_reg[79:48]),
        .older_core_mode (mode_reg),
        .result          (res_next)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

    // Checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg)
        else $error("accepted transaction lost before decode");

    a_multiple_is_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.is_multiple) |-> (res_reg.access_width == WIDTH_WORD))
        else $error("multiple transfer with non-word width");

    a_wb_only_multiple: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.is_multiple) |->
            (!res_reg.writeback_enable && res_reg.register_list == 16'd0))
        else $error("single transfer with writeback or list");

    a_advance_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("decoded transaction not presented");

endmodule

`default_nettype wire
